// File: rtl/les_pkg.sv
// Shared types, constants, microcode table and helpers for the Lorenz Euler stepper.
`default_nettype none
package les_pkg;

  // Number formats
  localparam int unsigned XLEN      = 32;                  // coordinate / coefficient width
  localparam int unsigned FRAC_BITS = 24;                  // fraction bits of coordinates
  localparam int unsigned STEP_BITS = 24;                  // width and scale of dt
  localparam int unsigned OPW       = XLEN + 1;            // multiplier operand width
  localparam int unsigned PW        = 2 * OPW;             // full product width
  localparam int unsigned EXT_W     = PW + 2;              // headroom for add/sub before clamp
  localparam int unsigned NUM_OUT   = 9;
  localparam int unsigned OUT_W     = NUM_OUT * XLEN;

  // Configuration register map
  localparam int unsigned CFG_IDX_W = 3;
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SIGMA  = 3'd0,
    CFG_RHO    = 3'd1,
    CFG_BETA   = 3'd2,
    CFG_INIT_X = 3'd3,
    CFG_INIT_Y = 3'd4,
    CFG_INIT_Z = 3'd5
  } cfg_idx_e;

  localparam logic signed [XLEN-1:0] RST_SIGMA  = 32'sd167772160;
  localparam logic signed [XLEN-1:0] RST_RHO    = 32'sd469762048;
  localparam logic signed [XLEN-1:0] RST_BETA   = 32'sd44739243;
  localparam logic signed [XLEN-1:0] RST_INIT_X = 32'sd16777216;
  localparam logic signed [XLEN-1:0] RST_INIT_Y = 32'sd16777216;
  localparam logic signed [XLEN-1:0] RST_INIT_Z = 32'sd16777216;

  localparam logic signed [XLEN-1:0] VAL_MAX = {1'b0, {(XLEN-1){1'b1}}};
  localparam logic signed [XLEN-1:0] VAL_MIN = {1'b1, {(XLEN-1){1'b0}}};

  typedef struct packed {
    logic signed [XLEN-1:0] sigma;
    logic signed [XLEN-1:0] rho;
    logic signed [XLEN-1:0] beta;
    logic signed [XLEN-1:0] init_x;
    logic signed [XLEN-1:0] init_y;
    logic signed [XLEN-1:0] init_z;
  } cfg_t;

  // Datapath operations, one per control word
  typedef enum logic [3:0] {
    OP_NOP,
    OP_LOAD,   // latch dt, reload point on start
    OP_DX,     // dx = sat(prod >>> F)
    OP_DY,     // dy = sat((prod >>> F) - y)
    OP_T,      // t  = prod >>> F
    OP_DZ,     // dz = sat(t - (prod >>> F))
    OP_X,      // x  = sat(x + (prod >>> S))
    OP_Y,
    OP_Z,
    OP_EXT     // fold point into extremes
  } op_e;

  typedef enum logic [2:0] {
    A_SIGMA,
    A_X,
    A_BETA,
    A_DX,
    A_DY,
    A_DZ
  } asel_e;

  typedef enum logic [2:0] {
    B_YMX,     // y - x
    B_RMZ,     // rho - z
    B_Y,
    B_Z,
    B_DT
  } bsel_e;

  typedef enum logic [1:0] {
    H_NONE,
    H_NO_BEAT,   // wait for an input beat
    H_OUT_BUSY   // wait for the output register
  } hold_e;

  // Sequencer
  localparam int unsigned NUM_STEPS = 11;
  localparam int unsigned PC_W      = $clog2(NUM_STEPS);
  typedef logic [PC_W-1:0] pc_t;

  typedef struct packed {
    logic  accept;
    logic  emit;
    hold_e hold;
    logic  jmp;
    pc_t   tgt;
    op_e   op;
    asel_e a_sel;
    bsel_e b_sel;
  } cw_t;

  typedef struct packed {
    op_e   op;
    asel_e a_sel;
    bsel_e b_sel;
  } dp_ctrl_t;

  // Microcode: the product formed in one step is written back in the next
  function automatic cw_t rom_word(input pc_t pc);
    cw_t w;
    w = '{accept: 1'b0, emit: 1'b0, hold: H_NONE, jmp: 1'b0, tgt: '0,
          op: OP_NOP, a_sel: A_SIGMA, b_sel: B_YMX};
    case (pc)
      pc_t'(0): begin
        w.accept = 1'b1;
        w.hold   = H_NO_BEAT;
        w.op     = OP_LOAD;
      end
      pc_t'(1): begin
        w.a_sel = A_SIGMA; w.b_sel = B_YMX;
      end
      pc_t'(2): begin
        w.op = OP_DX; w.a_sel = A_X; w.b_sel = B_RMZ;
      end
      pc_t'(3): begin
        w.op = OP_DY; w.a_sel = A_X; w.b_sel = B_Y;
      end
      pc_t'(4): begin
        w.op = OP_T; w.a_sel = A_BETA; w.b_sel = B_Z;
      end
      pc_t'(5): begin
        w.op = OP_DZ; w.a_sel = A_DX; w.b_sel = B_DT;
      end
      pc_t'(6): begin
        w.op = OP_X; w.a_sel = A_DY; w.b_sel = B_DT;
      end
      pc_t'(7): begin
        w.op = OP_Y; w.a_sel = A_DZ; w.b_sel = B_DT;
      end
      pc_t'(8): begin
        w.op = OP_Z;
      end
      pc_t'(9): begin
        w.op = OP_EXT;
      end
      pc_t'(10): begin
        w.emit = 1'b1;
        w.hold = H_OUT_BUSY;
        w.jmp  = 1'b1;
        w.tgt  = '0;
      end
      default: begin
        w.jmp = 1'b1;
        w.tgt = '0;
      end
    endcase
    return w;
  endfunction

  // Clamp a widened value to the signed coordinate range
  function automatic logic signed [XLEN-1:0] sat32(input logic signed [EXT_W-1:0] v);
    logic signed [EXT_W-1:0] hi;
    logic signed [EXT_W-1:0] lo;
    hi = {{(EXT_W-XLEN){1'b0}}, VAL_MAX};
    lo = {{(EXT_W-XLEN){1'b1}}, VAL_MIN};
    if (v > hi) begin
      return VAL_MAX;
    end else if (v < lo) begin
      return VAL_MIN;
    end else begin
      return v[XLEN-1:0];
    end
  endfunction

endpackage
`default_nettype wire

// File: rtl/lorenz_euler_stepper_core.sv
// Top level of the forward Euler Lorenz stepper.
//
// Each input beat (dt in tdata, start flag in tuser) advances the Lorenz point
// by one forward Euler step in signed Q8.24 and returns one output beat with
// the new point and the running minima and maxima. An item passes through
// one accept step, nine steps of a microcoded program that share a single
// 33x33 multiplier (one product per step, written back in the next step), and
// one step that moves the result into the output register. If that register is
// still held by a stalled sink the program waits there. Coefficients and the
// starting point come from the write-only configuration port; the starting
// point is only taken in on a beat with the start flag set.
`default_nettype none
module lorenz_euler_stepper_core (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  // configuration
  input  wire logic                            cfg_we_i,
  input  wire logic [les_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  wire logic [les_pkg::XLEN-1:0]        cfg_data_i,
  // input stream
  input  wire logic                            s_axis_tvalid,
  output logic                                 s_axis_tready,
  input  wire logic [les_pkg::STEP_BITS-1:0]   s_axis_tdata,  // [23:0] step_size
  input  wire logic                            s_axis_tuser,  // [0] start_req
  // output stream
  output logic                                 m_axis_tvalid,
  input  wire logic                            m_axis_tready,
  output logic [les_pkg::OUT_W-1:0]            m_axis_tdata   // out_x, out_y, out_z,
                                                              // low_x, low_y, low_z,
                                                              // high_x, high_y, high_z
);

  les_pkg::cfg_t     cfg;
  les_pkg::dp_ctrl_t ctrl;
  logic [les_pkg::OUT_W-1:0] result;
  logic [les_pkg::OUT_W-1:0] out_data_q, out_data_d;
  logic out_valid_q, out_valid_d;
  logic out_busy;
  logic out_load;

  les_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  les_seq u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .out_busy_i (out_busy),
    .in_ready_o (s_axis_tready),
    .out_load_o (out_load),
    .ctrl_o     (ctrl)
  );

  les_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (ctrl),
    .cfg_i       (cfg),
    .step_size_i (s_axis_tdata),
    .start_req_i (s_axis_tuser),
    .result_o    (result)
  );

  // Output register
  assign out_busy = out_valid_q & ~m_axis_tready;

  always_comb begin
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    if (out_load) begin
      out_valid_d = 1'b1;
      out_data_d  = result;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule
`default_nettype wire

// File: rtl/les_cfg.sv
// Configuration register file: coefficients and starting point.
`default_nettype none
module les_cfg (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                cfg_we_i,
  input  wire logic [les_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  wire logic [les_pkg::XLEN-1:0]            cfg_data_i,
  output les_pkg::cfg_t                            cfg_o
);

  les_pkg::cfg_t cfg_q, cfg_d;

  // Register write decode; unused indexes are dropped
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        les_pkg::CFG_SIGMA:  cfg_d.sigma  = cfg_data_i;
        les_pkg::CFG_RHO:    cfg_d.rho    = cfg_data_i;
        les_pkg::CFG_BETA:   cfg_d.beta   = cfg_data_i;
        les_pkg::CFG_INIT_X: cfg_d.init_x = cfg_data_i;
        les_pkg::CFG_INIT_Y: cfg_d.init_y = cfg_data_i;
        les_pkg::CFG_INIT_Z: cfg_d.init_z = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.sigma  <= les_pkg::RST_SIGMA;
      cfg_q.rho    <= les_pkg::RST_RHO;
      cfg_q.beta   <= les_pkg::RST_BETA;
      cfg_q.init_x <= les_pkg::RST_INIT_X;
      cfg_q.init_y <= les_pkg::RST_INIT_Y;
      cfg_q.init_z <= les_pkg::RST_INIT_Z;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule
`default_nettype wire

// File: rtl/les_seq.sv
// Microcode sequencer: step counter, control-word table and hold/jump logic.
`default_nettype none
module les_seq (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  input  wire logic        out_busy_i,
  output logic             in_ready_o,
  output logic             out_load_o,
  output les_pkg::dp_ctrl_t ctrl_o
);

  les_pkg::pc_t pc_q, pc_d;
  les_pkg::cw_t cw;
  logic         in_beat;
  logic         hold;

  assign cw      = les_pkg::rom_word(pc_q);
  assign in_ready_o = cw.accept;
  assign in_beat = cw.accept & in_valid_i;

  // Hold conditions stall the counter on the current step
  always_comb begin
    case (cw.hold)
      les_pkg::H_NO_BEAT:  hold = ~in_valid_i;
      les_pkg::H_OUT_BUSY: hold = out_busy_i;
      default:             hold = 1'b0;
    endcase
  end

  assign out_load_o = cw.emit & ~out_busy_i;

  // Datapath control; the load step only acts on an accepted beat
  always_comb begin
    ctrl_o.a_sel = cw.a_sel;
    ctrl_o.b_sel = cw.b_sel;
    ctrl_o.op    = (cw.accept && !in_beat) ? les_pkg::OP_NOP : cw.op;
  end

  // Next step
  always_comb begin
    if (hold) begin
      pc_d = pc_q;
    end else if (cw.jmp) begin
      pc_d = cw.tgt;
    end else begin
      pc_d = pc_q + les_pkg::pc_t'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= '0;
    end else begin
      pc_q <= pc_d;
    end
  end

endmodule
`default_nettype wire

// File: rtl/les_dp.sv
// Datapath: point and extreme registers, one shared multiplier, writeback ALU.
`default_nettype none
module les_dp (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire les_pkg::dp_ctrl_t                  ctrl_i,
  input  wire les_pkg::cfg_t                      cfg_i,
  input  wire logic [les_pkg::STEP_BITS-1:0]      step_size_i,
  input  wire logic                               start_req_i,
  output logic [les_pkg::OUT_W-1:0]               result_o
);

  localparam int unsigned XLEN  = les_pkg::XLEN;
  localparam int unsigned OPW   = les_pkg::OPW;
  localparam int unsigned PW    = les_pkg::PW;
  localparam int unsigned EXT_W = les_pkg::EXT_W;

  // Point and extremes
  logic signed [XLEN-1:0] pos_x_q, pos_y_q, pos_z_q, pos_x_d, pos_y_d, pos_z_d;
  logic signed [XLEN-1:0] min_x_q, min_y_q, min_z_q, min_x_d, min_y_d, min_z_d;
  logic signed [XLEN-1:0] max_x_q, max_y_q, max_z_q, max_x_d, max_y_d, max_z_d;
  // Work registers
  logic signed [XLEN-1:0] dx_q, dy_q, dz_q, dx_d, dy_d, dz_d;
  logic signed [PW-1:0]   t_q, t_d;
  logic signed [PW-1:0]   prod_q, prod_d;
  logic [les_pkg::STEP_BITS-1:0] dt_q, dt_d;

  logic signed [OPW-1:0]  op_a, op_b;
  logic signed [PW-1:0]   sh_frac, sh_step;

  // Operand A select
  always_comb begin
    case (ctrl_i.a_sel)
      les_pkg::A_SIGMA: op_a = OPW'(cfg_i.sigma);
      les_pkg::A_X:     op_a = OPW'(pos_x_q);
      les_pkg::A_BETA:  op_a = OPW'(cfg_i.beta);
      les_pkg::A_DX:    op_a = OPW'(dx_q);
      les_pkg::A_DY:    op_a = OPW'(dy_q);
      les_pkg::A_DZ:    op_a = OPW'(dz_q);
      default:          op_a = '0;
    endcase
  end

  // Operand B select, differences formed at full precision
  always_comb begin
    case (ctrl_i.b_sel)
      les_pkg::B_YMX: op_b = OPW'(pos_y_q) - OPW'(pos_x_q);
      les_pkg::B_RMZ: op_b = OPW'(cfg_i.rho) - OPW'(pos_z_q);
      les_pkg::B_Y:   op_b = OPW'(pos_y_q);
      les_pkg::B_Z:   op_b = OPW'(pos_z_q);
      les_pkg::B_DT:  op_b = $signed({{(OPW-les_pkg::STEP_BITS){1'b0}}, dt_q});
      default:        op_b = '0;
    endcase
  end

  // Shared multiplier, registered
  assign prod_d  = op_a * op_b;
  assign sh_frac = prod_q >>> les_pkg::FRAC_BITS;
  assign sh_step = prod_q >>> les_pkg::STEP_BITS;

  // Writeback
  always_comb begin
    pos_x_d = pos_x_q; pos_y_d = pos_y_q; pos_z_d = pos_z_q;
    min_x_d = min_x_q; min_y_d = min_y_q; min_z_d = min_z_q;
    max_x_d = max_x_q; max_y_d = max_y_q; max_z_d = max_z_q;
    dx_d = dx_q; dy_d = dy_q; dz_d = dz_q;
    t_d  = t_q;
    dt_d = dt_q;
    case (ctrl_i.op)
      les_pkg::OP_LOAD: begin
        dt_d = step_size_i;
        if (start_req_i) begin
          pos_x_d = cfg_i.init_x; pos_y_d = cfg_i.init_y; pos_z_d = cfg_i.init_z;
          min_x_d = les_pkg::VAL_MAX; min_y_d = les_pkg::VAL_MAX;
          min_z_d = les_pkg::VAL_MAX;
          max_x_d = les_pkg::VAL_MIN; max_y_d = les_pkg::VAL_MIN;
          max_z_d = les_pkg::VAL_MIN;
        end
      end
      les_pkg::OP_DX: dx_d = les_pkg::sat32(EXT_W'(sh_frac));
      les_pkg::OP_DY: dy_d = les_pkg::sat32(EXT_W'(sh_frac) - EXT_W'(pos_y_q));
      les_pkg::OP_T:  t_d  = sh_frac;
      les_pkg::OP_DZ: dz_d = les_pkg::sat32(EXT_W'(t_q) - EXT_W'(sh_frac));
      les_pkg::OP_X:  pos_x_d = les_pkg::sat32(EXT_W'(pos_x_q) + EXT_W'(sh_step));
      les_pkg::OP_Y:  pos_y_d = les_pkg::sat32(EXT_W'(pos_y_q) + EXT_W'(sh_step));
      les_pkg::OP_Z:  pos_z_d = les_pkg::sat32(EXT_W'(pos_z_q) + EXT_W'(sh_step));
      les_pkg::OP_EXT: begin
        if (pos_x_q < min_x_q) min_x_d = pos_x_q;
        if (pos_y_q < min_y_q) min_y_d = pos_y_q;
        if (pos_z_q < min_z_q) min_z_d = pos_z_q;
        if (pos_x_q > max_x_q) max_x_d = pos_x_q;
        if (pos_y_q > max_y_q) max_y_d = pos_y_q;
        if (pos_z_q > max_z_q) max_z_d = pos_z_q;
      end
      default: ;
    endcase
  end

  // Architectural state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_x_q <= les_pkg::RST_INIT_X;
      pos_y_q <= les_pkg::RST_INIT_Y;
      pos_z_q <= les_pkg::RST_INIT_Z;
      min_x_q <= les_pkg::VAL_MAX;
      min_y_q <= les_pkg::VAL_MAX;
      min_z_q <= les_pkg::VAL_MAX;
      max_x_q <= les_pkg::VAL_MIN;
      max_y_q <= les_pkg::VAL_MIN;
      max_z_q <= les_pkg::VAL_MIN;
    end else begin
      pos_x_q <= pos_x_d;
      pos_y_q <= pos_y_d;
      pos_z_q <= pos_z_d;
      min_x_q <= min_x_d;
      min_y_q <= min_y_d;
      min_z_q <= min_z_d;
      max_x_q <= max_x_d;
      max_y_q <= max_y_d;
      max_z_q <= max_z_d;
    end
  end

  // Scratch registers, no reset
  always_ff @(posedge clk_i) begin
    dx_q   <= dx_d;
    dy_q   <= dy_d;
    dz_q   <= dz_d;
    t_q    <= t_d;
    dt_q   <= dt_d;
    prod_q <= prod_d;
  end

  assign result_o = {max_z_q, max_y_q, max_x_q, min_z_q, min_y_q, min_x_q,
                     pos_z_q, pos_y_q, pos_x_q};

endmodule
`default_nettype wire

// File: bench/tb_lorenz_euler_stepper_core.sv
// Self-checking testbench for lorenz_euler_stepper_core: directed table, then random phases.
`default_nettype none
module tb_lorenz_euler_stepper_core;
  import les_pkg::*;

  localparam int unsigned ITEMS_PER_PHASE = 150;
  localparam int unsigned NUM_PHASES      = 8;
  localparam int unsigned DRAIN_CYCLES    = 16;
  localparam int unsigned MAX_REPORTS     = 100;
  localparam logic [STEP_BITS-1:0] DT_MAX = {STEP_BITS{1'b1}};

  // indexes past the register map, written to show they are ignored
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 3'd7;

  localparam logic [XLEN-1:0] RESET_REGS [6] = '{RST_SIGMA, RST_RHO, RST_BETA,
                                                 RST_INIT_X, RST_INIT_Y, RST_INIT_Z};

  typedef enum logic [1:0] {ROW_CFG, ROW_STEP, ROW_PINNED} row_kind_e;
  typedef enum int {SET_DEFAULT, SET_RANDOM, SET_LORENZ, SET_EXTREME} coef_set_e;

  // kind, register index, register value or dt, start flag, value expected in all nine fields
  typedef struct packed {
    row_kind_e             kind;
    logic [CFG_IDX_W-1:0]  idx;
    logic [XLEN-1:0]       value;
    logic                  start;
    logic [XLEN-1:0]       pin;
  } dir_row_t;

  localparam int unsigned NUM_ROWS = 30;
  localparam dir_row_t DIR_ROWS [NUM_ROWS] = '{
    '{ROW_PINNED, CFG_SIGMA,  32'd0,        1'b0, RST_INIT_X},  // zero step right after reset
    '{ROW_STEP,   CFG_SIGMA,  32'hFFFFFF,   1'b0, 32'd0},       // largest step, no start
    '{ROW_STEP,   CFG_SIGMA,  32'd167772,   1'b0, 32'd0},
    '{ROW_STEP,   CFG_SIGMA,  32'd1,        1'b1, 32'd0},
    '{ROW_STEP,   CFG_SIGMA,  32'h800000,   1'b0, 32'd0},
    '{ROW_CFG,    CFG_SIGMA,  VAL_MAX,      1'b0, 32'd0},
    '{ROW_CFG,    CFG_RHO,    VAL_MIN,      1'b0, 32'd0},
    '{ROW_CFG,    CFG_BETA,   VAL_MAX,      1'b0, 32'd0},
    '{ROW_CFG,    CFG_INIT_X, VAL_MAX,      1'b0, 32'd0},
    '{ROW_CFG,    CFG_INIT_Y, VAL_MIN,      1'b0, 32'd0},
    '{ROW_CFG,    CFG_INIT_Z, 32'd0,        1'b0, 32'd0},
    '{ROW_STEP,   CFG_SIGMA,  32'd0,        1'b0, 32'd0},       // new init not taken yet
    '{ROW_STEP,   CFG_SIGMA,  32'hFFFFFF,   1'b1, 32'd0},       // saturating derivatives
    '{ROW_STEP,   CFG_SIGMA,  32'hFFFFFF,   1'b0, 32'd0},
    '{ROW_CFG,    CFG_SPARE_A, 32'hFFFFFFFF, 1'b0, 32'd0},
    '{ROW_CFG,    CFG_SPARE_B, 32'h0,        1'b0, 32'd0},
    '{ROW_CFG,    CFG_INIT_X, VAL_MIN,      1'b0, 32'd0},
    '{ROW_CFG,    CFG_INIT_Y, VAL_MIN,      1'b0, 32'd0},
    '{ROW_CFG,    CFG_INIT_Z, VAL_MIN,      1'b0, 32'd0},
    '{ROW_PINNED, CFG_SIGMA,  32'd0,        1'b1, VAL_MIN},     // start at most negative
    '{ROW_STEP,   CFG_SIGMA,  32'hFFFFFF,   1'b0, 32'd0},
    '{ROW_CFG,    CFG_INIT_X, VAL_MAX,      1'b0, 32'd0},
    '{ROW_CFG,    CFG_INIT_Y, VAL_MAX,      1'b0, 32'd0},
    '{ROW_CFG,    CFG_INIT_Z, VAL_MAX,      1'b0, 32'd0},
    '{ROW_PINNED, CFG_SIGMA,  32'd0,        1'b1, VAL_MAX},     // start at most positive
    '{ROW_STEP,   CFG_SIGMA,  32'hFFFFFF,   1'b0, 32'd0},
    '{ROW_CFG,    CFG_SIGMA,  VAL_MIN,      1'b0, 32'd0},
    '{ROW_CFG,    CFG_RHO,    VAL_MAX,      1'b0, 32'd0},
    '{ROW_CFG,    CFG_BETA,   VAL_MIN,      1'b0, 32'd0},
    '{ROW_STEP,   CFG_SIGMA,  32'hFFFFFF,   1'b1, 32'd0}
  };

  localparam string FIELD_NAMES [NUM_OUT] = '{"out_x", "out_y", "out_z", "low_x", "low_y",
                                              "low_z", "high_x", "high_y", "high_z"};

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [XLEN-1:0]       cfg_data_i;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [STEP_BITS-1:0]  s_axis_tdata;   // [23:0] step_size
  logic                  s_axis_tuser;   // [0] start_req
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [OUT_W-1:0]      m_axis_tdata;   // out_x, out_y, out_z, low_x, low_y, low_z,
                                         // high_x, high_y, high_z

  // mirror of the block: coefficients, start point, current point, extremes
  int k_sigma, k_rho, k_beta;
  int init_pt [3];
  int pt [3];
  int lo [3];
  int hi [3];

  logic [OUT_W-1:0] expected_points [$];
  int               mismatch_count;
  bit               src_eager;
  bit               sink_eager;

  lorenz_euler_stepper_core i_dut (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_idx_i,
    .cfg_data_i,
    .s_axis_tvalid,
    .s_axis_tready,
    .s_axis_tdata,
    .s_axis_tuser,
    .m_axis_tvalid,
    .m_axis_tready,
    .m_axis_tdata
  );

  // clock
  initial clk_i = 1'b0;
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // run limit
  initial begin
    #5_000_000;
    $display("FAIL lorenz_euler_stepper_core");
    $finish;
  end

  function automatic int clamp32(input longint v);
    if (v > longint'(VAL_MAX)) begin
      return VAL_MAX;
    end else if (v < longint'(VAL_MIN)) begin
      return VAL_MIN;
    end
    return int'(v);
  endfunction

  // one Euler step of the mirror; returns the beat the block should send
  function automatic logic [OUT_W-1:0] lorenz_step(input logic [STEP_BITS-1:0] dt,
                                                   input logic start);
    longint px, py, pz, ddx, ddy, ddz, step;
    if (start) begin
      pt = init_pt;
      lo = '{VAL_MAX, VAL_MAX, VAL_MAX};
      hi = '{VAL_MIN, VAL_MIN, VAL_MIN};
    end
    px   = pt[0];
    py   = pt[1];
    pz   = pt[2];
    step = longint'(dt);
    ddx = clamp32((longint'(k_sigma) * (py - px)) >>> FRAC_BITS);
    ddy = clamp32(((px * (longint'(k_rho) - pz)) >>> FRAC_BITS) - py);
    ddz = clamp32(((px * py) >>> FRAC_BITS) - ((longint'(k_beta) * pz) >>> FRAC_BITS));
    pt[0] = clamp32(px + ((ddx * step) >>> STEP_BITS));
    pt[1] = clamp32(py + ((ddy * step) >>> STEP_BITS));
    pt[2] = clamp32(pz + ((ddz * step) >>> STEP_BITS));
    for (int i = 0; i < 3; i++) begin
      if (pt[i] < lo[i]) lo[i] = pt[i];
      if (pt[i] > hi[i]) hi[i] = pt[i];
    end
    return {hi[2], hi[1], hi[0], lo[2], lo[1], lo[0], pt[2], pt[1], pt[0]};
  endfunction

  task automatic report_mismatch(input string msg);
    if (mismatch_count < MAX_REPORTS) $display("%0t: %s", $realtime, msg);
    mismatch_count++;
  endtask

  // register write; the caller lowers cfg_we_i after the last one
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [XLEN-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    case (idx)
      CFG_SIGMA:  k_sigma    = int'(data);
      CFG_RHO:    k_rho      = int'(data);
      CFG_BETA:   k_beta     = int'(data);
      CFG_INIT_X: init_pt[0] = int'(data);
      CFG_INIT_Y: init_pt[1] = int'(data);
      CFG_INIT_Z: init_pt[2] = int'(data);
      default: ;
    endcase
  endtask

  // hold off the sender until every expected beat is back
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (expected_points.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // one input beat; valid stays high when the next beat follows at once
  task automatic send_step(input logic [STEP_BITS-1:0] dt, input logic start,
                           input logic pinned, input logic [XLEN-1:0] pin);
    int gap;
    logic [OUT_W-1:0] beat;
    gap = src_eager ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= dt;
    s_axis_tuser  <= start;
    do @(posedge clk_i); while (!s_axis_tready);
    beat = lorenz_step(dt, start);
    if (pinned) beat = {NUM_OUT{pin}};
    expected_points.push_back(beat);
  endtask

  function automatic logic [XLEN-1:0] pick_coef(input coef_set_e mode, input int r);
    logic [XLEN-1:0] v;
    case (mode)
      SET_DEFAULT: v = RESET_REGS[r];
      SET_RANDOM:  v = $urandom;
      SET_LORENZ: begin
        case (cfg_idx_e'(r))
          CFG_SIGMA: v = $urandom_range(0, 20 << FRAC_BITS);
          CFG_RHO:   v = $urandom_range(0, 50 << FRAC_BITS);
          CFG_BETA:  v = $urandom_range(0, 4 << FRAC_BITS);
          default:   v = $urandom_range(0, 40 << FRAC_BITS) - (20 << FRAC_BITS);
        endcase
      end
      default: begin
        case ($urandom_range(0, 2))
          0:       v = VAL_MAX;
          1:       v = VAL_MIN;
          default: v = '0;
        endcase
      end
    endcase
    return v;
  endfunction

  function automatic logic [STEP_BITS-1:0] pick_dt();
    int sel;
    sel = $urandom_range(0, 19);
    if (sel < 12) return STEP_BITS'($urandom_range(0, 400000));
    if (sel < 17) return STEP_BITS'($urandom);
    if (sel == 17) return '0;
    if (sel == 18) return DT_MAX;
    return STEP_BITS'($urandom_range(1, 15));
  endfunction

  // sink: random stalls, every accepted beat checked field by field
  initial begin : sink
    int stall;
    int beat_no;
    logic [OUT_W-1:0] want;
    m_axis_tready = 1'b0;
    beat_no = 0;
    do @(posedge clk_i); while (!rst_ni);
    forever begin
      stall = sink_eager ? 0 : $urandom_range(0, 5);
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      if (expected_points.size() == 0) begin
        report_mismatch($sformatf("beat %0d arrived with nothing expected", beat_no));
      end else begin
        want = expected_points.pop_front();
        for (int i = 0; i < NUM_OUT; i++) begin
          if (m_axis_tdata[i*XLEN +: XLEN] !== want[i*XLEN +: XLEN]) begin
            report_mismatch($sformatf("beat %0d %s: got %h expected %h", beat_no,
                                      FIELD_NAMES[i], m_axis_tdata[i*XLEN +: XLEN],
                                      want[i*XLEN +: XLEN]));
          end
        end
      end
      beat_no++;
    end
  end

  // stimulus
  initial begin : stim
    dir_row_t row;
    bit in_cfg;
    coef_set_e mode;
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = '0;
    cfg_data_i    = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = 1'b0;
    src_eager     = 1'b0;
    sink_eager    = 1'b0;
    mismatch_count = 0;
    in_cfg        = 1'b0;

    k_sigma = RST_SIGMA;
    k_rho   = RST_RHO;
    k_beta  = RST_BETA;
    init_pt = '{RST_INIT_X, RST_INIT_Y, RST_INIT_Z};
    pt      = init_pt;
    lo      = '{VAL_MAX, VAL_MAX, VAL_MAX};
    hi      = '{VAL_MIN, VAL_MIN, VAL_MIN};

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table
    foreach (DIR_ROWS[n]) begin
      row = DIR_ROWS[n];
      if (row.kind == ROW_CFG) begin
        if (!in_cfg) begin
          drain_results();
          in_cfg = 1'b1;
        end
        write_reg(row.idx, row.value);
      end else begin
        if (in_cfg) begin
          cfg_we_i <= 1'b0;
          in_cfg = 1'b0;
        end
        send_step(row.value[STEP_BITS-1:0], row.start, row.kind == ROW_PINNED, row.pin);
      end
    end

    // random phases, each writing a coefficient set chosen by phase % 4
    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      drain_results();
      mode = coef_set_e'(phase % 4);
      for (int r = 0; r < 6; r++) write_reg(cfg_idx_e'(r), pick_coef(mode, r));
      write_reg(phase[0] ? CFG_SPARE_A : CFG_SPARE_B, $urandom);
      cfg_we_i <= 1'b0;
      src_eager  = ($urandom_range(0, 3) == 0);
      sink_eager = ($urandom_range(0, 3) == 0);
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        // sender holds off mid-phase until the pipe is empty
        if (n == ITEMS_PER_PHASE / 2) drain_results();
        send_step(pick_dt(), (n == 0) || ($urandom_range(0, 15) == 0), 1'b0, '0);
      end
    end

    s_axis_tvalid <= 1'b0;
    while (expected_points.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("PASS lorenz_euler_stepper_core");
    end else begin
      $display("FAIL lorenz_euler_stepper_core");
    end
    $finish;
  end

endmodule
`default_nettype wire

// File: lorenz_euler_stepper_core.f
rtl/les_pkg.sv
rtl/les_cfg.sv
rtl/les_seq.sv
rtl/les_dp.sv
rtl/lorenz_euler_stepper_core.sv
bench/tb_lorenz_euler_stepper_core.sv
